FILE: design/gios_pkg.sv
// Shared widths, reset values and slot payload type for the interval suppressor.
package gios_pkg;

  localparam int unsigned POS_W  = 24;
  localparam int unsigned TOPK_W = 5;
  localparam int unsigned RANK_W = 4;

  localparam logic [TOPK_W-1:0] TOPK_RESET = TOPK_W'(5);

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [TOPK_W-1:0] topk_t;
  typedef logic [RANK_W-1:0] rank_t;

  // Bounds of one interval plus its well-formed flag (start <= stop).
  typedef struct packed {
    pos_t start_pos;
    pos_t stop_pos;
    logic ok;
  } slot_data_t;

endpackage

FILE: design/gios_in_if.sv
// Input channel: one interval beat with its first-of-group flag.
interface gios_in_if;
  import gios_pkg::*;

  logic valid;
  logic ready;
  logic group_start;
  pos_t start_pos;
  pos_t stop_pos;

  modport source (output valid, output group_start, output start_pos, output stop_pos,
                  input ready);
  modport sink   (input valid, input group_start, input start_pos, input stop_pos,
                  output ready);
endinterface

FILE: design/gios_out_if.sv
// Output channel: keep decision and slot rank for one interval.
interface gios_out_if;
  import gios_pkg::*;

  logic  valid;
  logic  ready;
  logic  keep;
  rank_t kept_rank;

  modport source (output valid, output keep, output kept_rank, input ready);
  modport sink   (input valid, input keep, input kept_rank, output ready);
endinterface

FILE: design/greedy_interval_overlap_suppression_top.sv
// Top level of the greedy interval overlap suppressor.
// Intervals of a group arrive best score first; each gets one result beat with a keep
// flag and, when kept, its slot rank. One interval is accepted every clock cycle unless
// the sink stalls; it passes the input register, then the result register. The rate
// is set by the bank of MAX_KEPT comparators that checks an interval against all kept
// slots at once, while the slot write and fill count update land on the same edge as the
// result, so the next interval already sees them. top_k saturates at MAX_KEPT; change it
// only while the block is idle.
module greedy_interval_overlap_suppression_top #(
  parameter int unsigned MAX_KEPT = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  gios_pkg::topk_t       cfg_wdata_i,
  gios_in_if.sink               in_i,
  gios_out_if.source            out_o
);
  import gios_pkg::*;

  localparam int unsigned IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_KEPT + 1);
  localparam int unsigned CMP_W = (CNT_W > TOPK_W) ? CNT_W : TOPK_W;

  topk_t            top_k_q;
  logic             in_vld_q;
  logic             in_first_q;
  pos_t             in_start_q;
  pos_t             in_stop_q;
  logic             out_vld_q;
  logic             keep_q, keep_d;
  rank_t            rank_q, rank_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] count_eff;
  logic [CNT_W-1:0] limit;
  logic [CMP_W-1:0] topk_ext;
  logic [CNT_W+RANK_W-1:0] rank_ext;
  logic             advance;
  logic             full;
  logic             hit;
  logic [MAX_KEPT-1:0] hit_vec;
  slot_data_t       query;

  assign advance   = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  // Config register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_k_q <= TOPK_RESET;
    end else if (cfg_we_i) begin
      top_k_q <= cfg_wdata_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_first_q <= in_i.group_start;
      in_start_q <= in_i.start_pos;
      in_stop_q  <= in_i.stop_pos;
    end
  end

  // Clear the kept set ahead of the first interval of a group.
  assign count_eff = in_first_q ? '0 : count_q;

  assign topk_ext = CMP_W'(top_k_q);
  assign limit    = (topk_ext > CMP_W'(MAX_KEPT)) ? CNT_W'(MAX_KEPT) : CNT_W'(topk_ext);
  assign full     = (count_eff >= limit);

  assign query.start_pos = in_start_q;
  assign query.stop_pos  = in_stop_q;
  assign query.ok        = (in_start_q <= in_stop_q);

  gios_slots #(
    .MAX_KEPT (MAX_KEPT),
    .IDX_W    (IDX_W)
  ) u_slots (
    .clk_i     (clk_i),
    .wr_en_i   (advance && keep_d),
    .wr_idx_i  (count_eff[IDX_W-1:0]),
    .wr_data_i (query),
    .query_i   (query),
    .hit_o     (hit_vec)
  );

  // Only slots below the fill count take part.
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < int'(MAX_KEPT); i++) begin
      if ((CNT_W'(i) < count_eff) && hit_vec[i]) begin
        hit = 1'b1;
      end
    end
  end

  assign keep_d   = !full && !hit;
  assign rank_ext = {{RANK_W{1'b0}}, count_eff};
  assign rank_d   = keep_d ? rank_ext[RANK_W-1:0] : '0;
  assign count_d  = keep_d ? count_eff + CNT_W'(1) : count_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        count_q <= count_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result register: hold while the sink stalls.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      keep_q <= keep_d;
      rank_q <= rank_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.keep      = keep_q;
  assign out_o.kept_rank = rank_q;

endmodule

FILE: design/gios_slots.sv
// Kept-interval slot bank with one parallel overlap comparator per slot.
module gios_slots #(
  parameter int unsigned MAX_KEPT = 16,
  parameter int unsigned IDX_W    = 4
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [IDX_W-1:0]          wr_idx_i,
  input  gios_pkg::slot_data_t      wr_data_i,
  input  gios_pkg::slot_data_t      query_i,
  output logic [MAX_KEPT-1:0]       hit_o
);
  import gios_pkg::*;

  slot_data_t slot_q [MAX_KEPT];

  // Slot contents are only read below the fill count, so no reset is needed.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slot_q[wr_idx_i] <= wr_data_i;
    end
  end

  // Inclusive overlap; a malformed interval on either side never overlaps.
  always_comb begin
    for (int i = 0; i < int'(MAX_KEPT); i++) begin
      hit_o[i] = slot_q[i].ok && query_i.ok &&
                 !((slot_q[i].stop_pos < query_i.start_pos) ||
                   (slot_q[i].start_pos > query_i.stop_pos));
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the greedy interval overlap suppressor top level.
module tb;
  import gios_pkg::*;

  localparam int unsigned MAX_KEPT    = 16;
  localparam int unsigned POS_MAX     = (1 << POS_W) - 1;
  localparam int unsigned CYCLE_CAP   = 300000;
  localparam int unsigned PHASE_ITEMS = 165;

  typedef struct packed {
    logic  keep;
    rank_t rank;
  } verdict_t;

  logic  clk;
  logic  rst_n;
  logic  cfg_we;
  topk_t cfg_wdata;

  gios_in_if  in_if ();
  gios_out_if out_if ();

  greedy_interval_overlap_suppression_top #(
    .MAX_KEPT(MAX_KEPT)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Shadow of the kept set and the group limit.
  verdict_t    pending_verdicts[$];
  topk_t       top_k_shadow;
  pos_t        kept_lo[MAX_KEPT];
  pos_t        kept_hi[MAX_KEPT];
  int unsigned kept_total;

  int unsigned burst_left;
  int unsigned stall_phase;
  int unsigned stall_mode;
  int          errors;
  int          intervals_sent;
  int          results_seen;
  int          kept_seen;
  int          last_slot_seen;
  int          settings_seen;

  always #5 clk = ~clk;

  function automatic verdict_t judge_interval(input bit first, input pos_t s, input pos_t e);
    int unsigned limit;
    bit          hit;
    verdict_t    v;
    v   = '0;
    hit = 1'b0;
    if (first) kept_total = 0;
    limit = (top_k_shadow > MAX_KEPT) ? MAX_KEPT : top_k_shadow;
    if (kept_total >= limit) return v;
    // Malformed bounds on either side never count as overlap; touching ends do.
    for (int i = 0; i < kept_total; i++) begin
      if (s <= e && kept_lo[i] <= kept_hi[i] && !(kept_hi[i] < s || kept_lo[i] > e))
        hit = 1'b1;
    end
    if (hit) return v;
    kept_lo[kept_total] = s;
    kept_hi[kept_total] = e;
    v.keep = 1'b1;
    v.rank = rank_t'(kept_total);
    kept_total++;
    return v;
  endfunction

  task automatic send_interval(input bit first, input int unsigned s, input int unsigned e);
    verdict_t v;
    @(negedge clk);
    if (burst_left == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    in_if.valid       = 1'b1;
    in_if.group_start = first;
    in_if.start_pos   = pos_t'(s);
    in_if.stop_pos    = pos_t'(e);
    do @(posedge clk); while (!in_if.ready);
    v = judge_interval(first, pos_t'(s), pos_t'(e));
    pending_verdicts.push_back(v);
    intervals_sent++;
    if (v.keep) begin
      kept_seen++;
      if (v.rank == rank_t'(MAX_KEPT - 1)) last_slot_seen++;
    end
  endtask

  // Drop valid and hold until every result beat has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_top_k(input topk_t k);
    wait_idle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = k;
    @(negedge clk);
    cfg_we       = 1'b0;
    top_k_shadow = k;
    settings_seen++;
  endtask

  // Runs on the group left by reset, default limit of five.
  task automatic test_overlap_rules();
    send_interval(1'b0, 100, 200);
    send_interval(1'b0, 200, 300);
    send_interval(1'b0, 50, 100);
    send_interval(1'b0, 201, 300);
    send_interval(1'b0, 500, 400);
    send_interval(1'b0, 450, 450);
    send_interval(1'b0, 0, 0);
    send_interval(1'b0, 1000, 1000);
  endtask

  task automatic test_extremes();
    send_interval(1'b1, 0, POS_MAX);
    send_interval(1'b0, POS_MAX, POS_MAX);
    send_interval(1'b0, POS_MAX, 0);
    send_interval(1'b1, POS_MAX, POS_MAX);
  endtask

  task automatic test_top_k_zero();
    write_top_k(topk_t'(0));
    send_interval(1'b1, 10, 20);
    send_interval(1'b0, 30, 40);
  endtask

  task automatic test_single_slot();
    write_top_k(topk_t'(1));
    send_interval(1'b1, 10, 20);
    send_interval(1'b0, 30, 40);
    send_interval(1'b1, 30, 40);
  endtask

  task automatic test_random_groups(input topk_t k, input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned s;
    int unsigned e;
    int unsigned w;
    int unsigned j;
    bit          first;
    int unsigned grp_lo[$];
    int unsigned grp_hi[$];
    write_top_k(k);
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 24);
      grp_lo.delete();
      grp_hi.delete();
      // Let some groups run on without a first flag.
      first = ($urandom_range(0, 9) != 0);
      for (int n = 0; n < len && sent < n_items; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_interval($urandom_range(0, 1), $urandom & POS_MAX, $urandom & POS_MAX);
        end else begin
          s = $urandom_range(0, POS_MAX);
          w = $urandom_range(0, 4095);
          e = (s + w > POS_MAX) ? POS_MAX : s + w;
          j = (grp_lo.size() > 0) ? $urandom_range(0, grp_lo.size() - 1) : 0;
          case ($urandom_range(0, 9))
            0: begin
              e = $urandom_range(0, POS_MAX - 1);
              s = $urandom_range(e + 1, POS_MAX);
            end
            1: if (grp_lo.size() > 0) begin
              // Start on an earlier interval's stop: touching overlap.
              s = grp_hi[j];
              w = $urandom_range(0, 300);
              e = (s + w > POS_MAX) ? POS_MAX : s + w;
            end
            2: if (grp_lo.size() > 0) begin
              e = grp_lo[j];
              w = $urandom_range(0, 300);
              s = (e > w) ? e - w : 0;
            end
            3: if (grp_lo.size() > 0) begin
              // Start just past an earlier interval's stop: adjacent, no overlap.
              s = (grp_hi[j] >= POS_MAX) ? POS_MAX : grp_hi[j] + 1;
              w = $urandom_range(0, 300);
              e = (s + w > POS_MAX) ? POS_MAX : s + w;
            end
            default: ;
          endcase
          send_interval(first && n == 0, s, e);
          grp_lo.push_back(s);
          grp_hi.push_back(e);
        end
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin : check_result
    verdict_t got;
    verdict_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.keep, out_if.kept_rank};
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result beat keep %0b rank %0d", $time, got.keep, got.rank);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected keep %0b rank %0d, actual keep %0b rank %0d",
                   $time, want.keep, want.rank, got.keep, got.rank);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern, switching among four styles.
  always @(negedge clk) begin
    stall_phase++;
    if (stall_phase % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_if.ready = 1'b1;
      1: out_if.ready = ($urandom_range(0, 9) < 7);
      2: out_if.ready = ((stall_phase % 5) < 2);
      default: out_if.ready = ((stall_phase % 16) >= 10);
    endcase
  end

  initial begin
    repeat (CYCLE_CAP) @(posedge clk);
    $display("Timeout after %0d cycles", CYCLE_CAP);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.group_start = 1'b0;
    in_if.start_pos   = '0;
    in_if.stop_pos    = '0;
    out_if.ready      = 1'b1;
    stall_phase       = 0;
    stall_mode        = 0;
    top_k_shadow      = TOPK_RESET;
    kept_total        = 0;
    burst_left        = 0;
    errors            = 0;
    intervals_sent    = 0;
    results_seen      = 0;
    kept_seen         = 0;
    last_slot_seen    = 0;
    settings_seen     = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_overlap_rules();
    test_extremes();
    test_top_k_zero();
    test_single_slot();
    test_random_groups(topk_t'(31), PHASE_ITEMS);
    test_random_groups(topk_t'(16), PHASE_ITEMS);
    test_random_groups(topk_t'(17), PHASE_ITEMS);
    test_random_groups(topk_t'(3), PHASE_ITEMS);
    test_random_groups(topk_t'(1), PHASE_ITEMS);
    test_random_groups(topk_t'(8), PHASE_ITEMS);
    test_random_groups(topk_t'($urandom_range(2, 30)), PHASE_ITEMS);
    test_random_groups(topk_t'(5), PHASE_ITEMS);

    wait_idle();
    repeat (4) @(posedge clk);
    $display("Covered %0d intervals and %0d result beats over %0d group limits from 0 to 31",
             intervals_sent, results_seen, settings_seen);
    $display("Kept %0d intervals, %0d of them in the last slot", kept_seen, last_slot_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
